### design/chi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular hue interpolator package
// Shared widths, defaults and elaboration helpers for the hue interpolator.
// ----------------------------------------------------------------------------
package chi_pkg;

    // Field widths of the input and result words.
    localparam int HUE_W = 11;
    localparam int CNT_W = 16;

    // Width that holds any circle size plus a hue, used for compares.
    localparam int CMP_W = 17;

    // Number of distinct codes of a hue field.
    localparam int HUE_RANGE = 1 << HUE_W;

    // Default number of positions on the hue circle.
    localparam int HUE_STEPS_DEFAULT = 1536;

    // Number of conditional subtract steps that reduce a hue field modulo
    // the circle size: the smallest n with (circle << n) above every hue
    // code, and never less than one stage.
    function automatic int reduce_stages(input int circle);
        int n;
        n = 0;
        for (int k = 0; k < CMP_W; k++)
        begin
            if ((circle << n) < HUE_RANGE)
            begin
                n = n + 1;
            end
        end
        if (n == 0)
        begin
            n = 1;
        end
        return n;
    endfunction

endpackage

### design/chi_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hue reduction pipeline
// Reduces start and stop hues modulo the circle size, one conditional
// subtract of a shifted circle size per stage, and clamps the step index.
// ----------------------------------------------------------------------------
module chi_reduce #(
    parameter int HUE_STEPS = chi_pkg::HUE_STEPS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [chi_pkg::HUE_W-1:0]  start_hue,
    input  logic [chi_pkg::HUE_W-1:0]  stop_hue,
    input  logic [chi_pkg::CNT_W-1:0]  step_count,
    input  logic [chi_pkg::CNT_W-1:0]  step_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [chi_pkg::HUE_W-1:0]  start_red,
    output logic [chi_pkg::HUE_W-1:0]  stop_red,
    output logic [chi_pkg::CNT_W-1:0]  count_out,
    output logic [chi_pkg::CNT_W-1:0]  index_out
);

    localparam int NS    = chi_pkg::reduce_stages(HUE_STEPS);
    localparam int HW    = chi_pkg::HUE_W;
    localparam int CW    = chi_pkg::CNT_W;
    localparam int CMPW  = chi_pkg::CMP_W;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_ready;
    logic [HW-1:0] start_reg  [NS];
    logic [HW-1:0] stop_reg   [NS];
    logic [CW-1:0] count_reg  [NS];
    logic [CW-1:0] index_reg  [NS];
    logic [HW-1:0] start_next [NS];
    logic [HW-1:0] stop_next  [NS];

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_stage
            localparam int SH = NS - 1 - i;
            localparam logic [CMPW-1:0] SUB = CMPW'(HUE_STEPS) << SH;

            logic          v_in;
            logic [HW-1:0] start_in;
            logic [HW-1:0] stop_in;
            logic [CW-1:0] count_in;
            logic [CW-1:0] index_in;
            logic          ready_dn;

            // Stage inputs: the port for the first stage, else the stage before.
            if (i == 0)
            begin : g_first
                assign v_in     = in_valid;
                assign start_in = start_hue;
                assign stop_in  = stop_hue;
                assign count_in = step_count;
                assign index_in = (step_index > step_count) ? step_count : step_index;
            end
            else
            begin : g_mid
                assign v_in     = valid_reg[i-1];
                assign start_in = start_reg[i-1];
                assign stop_in  = stop_reg[i-1];
                assign count_in = count_reg[i-1];
                assign index_in = index_reg[i-1];
            end

            if (i == NS - 1)
            begin : g_last_rdy
                assign ready_dn = out_ready;
            end
            else
            begin : g_mid_rdy
                assign ready_dn = stage_ready[i+1];
            end

            // A stage takes a new word when it is empty or its word moves on.
            assign stage_ready[i] = !valid_reg[i] || ready_dn;

            // Conditional subtract of the shifted circle size.
            always_comb
            begin
                start_next[i] = start_in;
                stop_next[i]  = stop_in;
                if (CMPW'(start_in) >= SUB)
                begin
                    start_next[i] = HW'(CMPW'(start_in) - SUB);
                end
                if (CMPW'(stop_in) >= SUB)
                begin
                    stop_next[i] = HW'(CMPW'(stop_in) - SUB);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (stage_ready[i])
                begin
                    valid_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[i] && v_in)
                begin
                    start_reg[i] <= start_next[i];
                    stop_reg[i]  <= stop_next[i];
                    count_reg[i] <= count_in;
                    index_reg[i] <= index_in;
                end
            end
        end
    endgenerate

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NS-1];
    assign start_red = start_reg[NS-1];
    assign stop_red  = stop_reg[NS-1];
    assign count_out = count_reg[NS-1];
    assign index_out = index_reg[NS-1];

endmodule

### design/chi_dist_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance and product stages
// Picks the shorter way around the circle and its direction, then forms
// the product of the distance and the clamped step index.
// ----------------------------------------------------------------------------
module chi_dist_mul #(
    parameter int HUE_STEPS = chi_pkg::HUE_STEPS_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [chi_pkg::HUE_W-1:0]                  start_red,
    input  logic [chi_pkg::HUE_W-1:0]                  stop_red,
    input  logic [chi_pkg::CNT_W-1:0]                  count_in,
    input  logic [chi_pkg::CNT_W-1:0]                  index_in,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [chi_pkg::HUE_W-1:0]                  start_out,
    output logic                                       up_out,
    output logic                                       zero_out,
    output logic [chi_pkg::CNT_W-1:0]                  count_out,
    output logic [$clog2(HUE_STEPS/2+1)+chi_pkg::CNT_W-1:0] prod_out
);

    localparam int HW   = chi_pkg::HUE_W;
    localparam int CW   = chi_pkg::CNT_W;
    localparam int CMPW = chi_pkg::CMP_W;
    localparam int DW   = $clog2(HUE_STEPS/2 + 1);
    localparam int PW   = DW + CW;
    localparam logic [CMPW-1:0] HALF  = CMPW'(HUE_STEPS / 2);
    localparam logic [CMPW-1:0] CIRC  = CMPW'(HUE_STEPS);

    // Stage one: distance and direction.
    logic          v1_reg;
    logic          rdy1;
    logic [HW-1:0] start1_reg;
    logic [DW-1:0] dist1_reg;
    logic          up1_reg;
    logic          zero1_reg;
    logic [CW-1:0] count1_reg;
    logic [CW-1:0] index1_reg;

    logic [HW-1:0] direct;
    logic          up_dir;
    logic [DW-1:0] dist1_next;
    logic          up1_next;

    // Stage two: product.
    logic          v2_reg;
    logic          rdy2;
    logic [HW-1:0] start2_reg;
    logic          up2_reg;
    logic          zero2_reg;
    logic [CW-1:0] count2_reg;
    logic [PW-1:0] prod2_reg;
    logic [PW-1:0] prod2_next;

    // Direct distance, and the wrap across zero when it exceeds half a turn.
    always_comb
    begin
        up_dir = (start_red <= stop_red);
        direct = up_dir ? (stop_red - start_red) : (start_red - stop_red);
        if (CMPW'(direct) > HALF)
        begin
            dist1_next = DW'(CIRC - CMPW'(direct));
            up1_next   = !up_dir;
        end
        else
        begin
            dist1_next = DW'(direct);
            up1_next   = up_dir;
        end
    end

    assign rdy2 = !v2_reg || out_ready;
    assign rdy1 = !v1_reg || rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            start1_reg <= start_red;
            dist1_reg  <= dist1_next;
            up1_reg    <= up1_next;
            zero1_reg  <= (count_in == '0);
            count1_reg <= count_in;
            index1_reg <= index_in;
        end
    end

    // Distance times step index.
    assign prod2_next = PW'(dist1_reg) * PW'(index1_reg);

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            start2_reg <= start1_reg;
            up2_reg    <= up1_reg;
            zero2_reg  <= zero1_reg;
            count2_reg <= count1_reg;
            prod2_reg  <= prod2_next;
        end
    end

    assign in_ready  = rdy1;
    assign out_valid = v2_reg;
    assign start_out = start2_reg;
    assign up_out    = up2_reg;
    assign zero_out  = zero2_reg;
    assign count_out = count2_reg;
    assign prod_out  = prod2_reg;

endmodule

### design/chi_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides the product by the step count, one quotient bit per stage,
// carrying the start hue, direction and zero flag alongside.
// ----------------------------------------------------------------------------
module chi_divider #(
    parameter int HUE_STEPS = chi_pkg::HUE_STEPS_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [chi_pkg::HUE_W-1:0]                  start_in,
    input  logic                                       up_in,
    input  logic                                       zero_in,
    input  logic [chi_pkg::CNT_W-1:0]                  count_in,
    input  logic [$clog2(HUE_STEPS/2+1)+chi_pkg::CNT_W-1:0] prod_in,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [chi_pkg::HUE_W-1:0]                  start_out,
    output logic                                       up_out,
    output logic                                       zero_out,
    output logic [$clog2(HUE_STEPS/2+1)-1:0]           delta_out
);

    localparam int HW = chi_pkg::HUE_W;
    localparam int CW = chi_pkg::CNT_W;
    localparam int DW = $clog2(HUE_STEPS/2 + 1);
    localparam int PW = DW + CW;

    logic [DW-1:0] valid_reg;
    logic [DW-1:0] stage_ready;
    logic [HW-1:0] start_reg [DW];
    logic          up_reg    [DW];
    logic          zero_reg  [DW];
    logic [CW-1:0] count_reg [DW];
    logic [PW-1:0] rem_reg   [DW];
    logic [DW-1:0] quot_reg  [DW];
    logic [PW-1:0] rem_next  [DW];
    logic [DW-1:0] quot_next [DW];

    genvar i;
    generate
        for (i = 0; i < DW; i++)
        begin : g_stage
            localparam int B = DW - 1 - i;

            logic          v_in;
            logic [HW-1:0] start_s;
            logic          up_s;
            logic          zero_s;
            logic [CW-1:0] count_s;
            logic [PW-1:0] rem_s;
            logic [DW-1:0] quot_s;
            logic [PW-1:0] divisor;
            logic          ready_dn;

            if (i == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign start_s = start_in;
                assign up_s    = up_in;
                assign zero_s  = zero_in;
                assign count_s = count_in;
                assign rem_s   = prod_in;
                assign quot_s  = '0;
            end
            else
            begin : g_mid
                assign v_in    = valid_reg[i-1];
                assign start_s = start_reg[i-1];
                assign up_s    = up_reg[i-1];
                assign zero_s  = zero_reg[i-1];
                assign count_s = count_reg[i-1];
                assign rem_s   = rem_reg[i-1];
                assign quot_s  = quot_reg[i-1];
            end

            if (i == DW - 1)
            begin : g_last_rdy
                assign ready_dn = out_ready;
            end
            else
            begin : g_mid_rdy
                assign ready_dn = stage_ready[i+1];
            end

            assign stage_ready[i] = !valid_reg[i] || ready_dn;

            // Try the step count shifted to this quotient bit.
            assign divisor = PW'(count_s) << B;

            always_comb
            begin
                rem_next[i]  = rem_s;
                quot_next[i] = quot_s;
                if (rem_s >= divisor)
                begin
                    rem_next[i]  = rem_s - divisor;
                    quot_next[i] = quot_s | (DW'(1) << B);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (stage_ready[i])
                begin
                    valid_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[i] && v_in)
                begin
                    start_reg[i] <= start_s;
                    up_reg[i]    <= up_s;
                    zero_reg[i]  <= zero_s;
                    count_reg[i] <= count_s;
                    rem_reg[i]   <= rem_next[i];
                    quot_reg[i]  <= quot_next[i];
                end
            end
        end
    endgenerate

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[DW-1];
    assign start_out = start_reg[DW-1];
    assign up_out    = up_reg[DW-1];
    assign zero_out  = zero_reg[DW-1];
    assign delta_out = quot_reg[DW-1];

endmodule

### design/chi_wrap_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrap and output stage
// Moves the start hue by the quotient in the chosen direction, wraps it
// onto the circle and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module chi_wrap_out #(
    parameter int HUE_STEPS = chi_pkg::HUE_STEPS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [chi_pkg::HUE_W-1:0]         start_in,
    input  logic                              up_in,
    input  logic                              zero_in,
    input  logic [$clog2(HUE_STEPS/2+1)-1:0]  delta_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [chi_pkg::HUE_W-1:0]         hue_out,
    output logic                              zero_steps
);

    localparam int HW   = chi_pkg::HUE_W;
    localparam int CMPW = chi_pkg::CMP_W;
    localparam logic [CMPW-1:0] CIRC = CMPW'(HUE_STEPS);

    logic            valid_reg;
    logic [HW-1:0]   hue_reg;
    logic            zero_reg;
    logic [CMPW-1:0] moved;
    logic [CMPW-1:0] wrapped;
    logic [HW-1:0]   hue_next;

    // Forward adds the quotient, backward adds one turn less the quotient.
    always_comb
    begin
        if (up_in)
        begin
            moved = CMPW'(start_in) + CMPW'(delta_in);
        end
        else
        begin
            moved = CMPW'(start_in) + CIRC - CMPW'(delta_in);
        end
        wrapped  = (moved >= CIRC) ? (moved - CIRC) : moved;
        hue_next = zero_in ? start_in : wrapped[HW-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg  <= hue_next;
            zero_reg <= zero_in;
        end
    end

    assign out_valid  = valid_reg;
    assign hue_out    = hue_reg;
    assign zero_steps = zero_reg;

endmodule

### design/circular_hue_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular hue interpolator
// Interpolates between two hues the shorter way around the hue circle.
// ----------------------------------------------------------------------------
// One word goes in and one result word comes out per cycle while out_stall
// is low. Each word passes R hue reduction stages (1 for the default
// 1536-position circle), the distance and product stages, D divider
// stages of one quotient bit each, where D = clog2(HUE_STEPS/2 + 1) (10 for
// the default circle), and the output register. A zero step count returns
// the reduced start hue with zero_steps set, and a step index above the
// step count is taken as the step count. The pipeline stages advance
// independently, so an empty stage is filled even while the output word is
// stalled.
// ----------------------------------------------------------------------------
module circular_hue_interpolator_unit #(
    parameter int HUE_STEPS = chi_pkg::HUE_STEPS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [chi_pkg::HUE_W-1:0]  start_hue,
    input  logic [chi_pkg::HUE_W-1:0]  stop_hue,
    input  logic [chi_pkg::CNT_W-1:0]  step_count,
    input  logic [chi_pkg::CNT_W-1:0]  step_index,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [chi_pkg::HUE_W-1:0]  hue_out,
    output logic                       zero_steps
);

    localparam int HW = chi_pkg::HUE_W;
    localparam int CW = chi_pkg::CNT_W;
    localparam int DW = $clog2(HUE_STEPS/2 + 1);
    localparam int PW = DW + CW;

    logic          in_ready;

    logic          red_valid;
    logic          red_ready;
    logic [HW-1:0] red_start;
    logic [HW-1:0] red_stop;
    logic [CW-1:0] red_count;
    logic [CW-1:0] red_index;

    logic          mul_valid;
    logic          mul_ready;
    logic [HW-1:0] mul_start;
    logic          mul_up;
    logic          mul_zero;
    logic [CW-1:0] mul_count;
    logic [PW-1:0] mul_prod;

    logic          div_valid;
    logic          div_ready;
    logic [HW-1:0] div_start;
    logic          div_up;
    logic          div_zero;
    logic [DW-1:0] div_delta;

    assign in_stall = !in_ready;

    // Hue reduction and index clamp.
    chi_reduce #(
        .HUE_STEPS (HUE_STEPS)
    ) u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_hue  (start_hue),
        .stop_hue   (stop_hue),
        .step_count (step_count),
        .step_index (step_index),
        .out_valid  (red_valid),
        .out_ready  (red_ready),
        .start_red  (red_start),
        .stop_red   (red_stop),
        .count_out  (red_count),
        .index_out  (red_index)
    );

    // Shorter distance and its product with the step index.
    chi_dist_mul #(
        .HUE_STEPS (HUE_STEPS)
    ) u_dist_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .start_red (red_start),
        .stop_red  (red_stop),
        .count_in  (red_count),
        .index_in  (red_index),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .start_out (mul_start),
        .up_out    (mul_up),
        .zero_out  (mul_zero),
        .count_out (mul_count),
        .prod_out  (mul_prod)
    );

    // Division by the step count.
    chi_divider #(
        .HUE_STEPS (HUE_STEPS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .start_in  (mul_start),
        .up_in     (mul_up),
        .zero_in   (mul_zero),
        .count_in  (mul_count),
        .prod_in   (mul_prod),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .start_out (div_start),
        .up_out    (div_up),
        .zero_out  (div_zero),
        .delta_out (div_delta)
    );

    // Final step on the circle and output register.
    chi_wrap_out #(
        .HUE_STEPS (HUE_STEPS)
    ) u_wrap_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .start_in   (div_start),
        .up_in      (div_up),
        .zero_in    (div_zero),
        .delta_in   (div_delta),
        .out_valid  (out_valid),
        .out_ready  (!out_stall),
        .hue_out    (hue_out),
        .zero_steps (zero_steps)
    );

endmodule

### tb/hue_interp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hue interpolator checker
// Watches both channels of the hue interpolator. It computes the expected
// hue of every accepted input word, queues it, and compares each accepted
// result word field by field against the oldest expected hue.
// ----------------------------------------------------------------------------
module hue_interp_checker #(
    parameter int HUE_STEPS = chi_pkg::HUE_STEPS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [chi_pkg::HUE_W-1:0]  start_hue,
    input  logic [chi_pkg::HUE_W-1:0]  stop_hue,
    input  logic [chi_pkg::CNT_W-1:0]  step_count,
    input  logic [chi_pkg::CNT_W-1:0]  step_index,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [chi_pkg::HUE_W-1:0]  hue_out,
    input  logic                       zero_steps,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [chi_pkg::HUE_W-1:0] hue;
        logic                      zero;
    } hue_word_t;

    hue_word_t expected_hues[$];
    int        errors = 0;

    // Interpolated hue along the shorter arc between the two reduced hues.
    function automatic hue_word_t interpolate_hue(
        input logic [chi_pkg::HUE_W-1:0] from_hue,
        input logic [chi_pkg::HUE_W-1:0] to_hue,
        input logic [chi_pkg::CNT_W-1:0] total,
        input logic [chi_pkg::CNT_W-1:0] current
    );
        int unsigned from_pos;
        int unsigned to_pos;
        int unsigned steps;
        int unsigned step;
        int unsigned span;
        int unsigned advance;
        int unsigned circle;
        int unsigned result;
        bit          rising;
        hue_word_t   word;
        circle   = HUE_STEPS;
        from_pos = 32'(from_hue);
        to_pos   = 32'(to_hue);
        from_pos = from_pos % circle;
        to_pos   = to_pos % circle;
        steps    = 32'(total);
        step     = 32'(current);
        word     = '0;

        // A zero step count hands back the start hue with the flag raised.
        if (steps == 0)
        begin
            word.hue  = from_pos[chi_pkg::HUE_W-1:0];
            word.zero = 1'b1;
            return word;
        end

        if (step > steps)
        begin
            step = steps;
        end

        if (from_pos <= to_pos)
        begin
            span   = to_pos - from_pos;
            rising = 1'b1;
        end
        else
        begin
            span   = from_pos - to_pos;
            rising = 1'b0;
        end

        // More than half the circle apart: go the other way across the wrap.
        if (span > circle / 2)
        begin
            span   = circle - span;
            rising = !rising;
        end

        advance = (span * step) / steps;
        if (rising)
        begin
            result = (from_pos + advance) % circle;
        end
        else
        begin
            result = (from_pos + circle - advance) % circle;
        end
        word.hue  = result[chi_pkg::HUE_W-1:0];
        word.zero = 1'b0;
        return word;
    endfunction

    // Check results first, then queue the expectation of a new input word,
    // so a word accepted in this cycle never matches a result of this cycle.
    always @(posedge clk or negedge rst_n)
    begin
        hue_word_t wanted;
        if (!rst_n)
        begin
            expected_hues.delete();
            pending    <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hues.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, got hue %0d zero %0d",
                             $time, hue_out, zero_steps);
                end
                else
                begin
                    wanted = expected_hues.pop_front();
                    if (hue_out !== wanted.hue)
                    begin
                        errors++;
                        $display("%0t: hue_out mismatch, expected %0d, got %0d",
                                 $time, wanted.hue, hue_out);
                    end
                    if (zero_steps !== wanted.zero)
                    begin
                        errors++;
                        $display("%0t: zero_steps mismatch, expected %0d, got %0d",
                                 $time, wanted.zero, zero_steps);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_hues.push_back(
                    interpolate_hue(start_hue, stop_hue, step_count, step_index));
            end
            pending    <= expected_hues.size();
            fail_count <= errors;
        end
    end

endmodule

### tb/circular_hue_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hue interpolator testbench
// Drives directed corner words and then random fades and loose words into
// the hue interpolator with random gaps and output stalls; a separate
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module circular_hue_interpolator_unit_tb;

    localparam int HUE_STEPS    = chi_pkg::HUE_STEPS_DEFAULT;
    localparam int HALF_CIRCLE  = HUE_STEPS / 2;
    localparam int WORD_TARGET  = 1350;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CALM_FIRST   = 600;
    localparam int CALM_LAST    = 800;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [chi_pkg::HUE_W-1:0]  start_hue;
    logic [chi_pkg::HUE_W-1:0]  stop_hue;
    logic [chi_pkg::CNT_W-1:0]  step_count;
    logic [chi_pkg::CNT_W-1:0]  step_index;
    logic                       out_valid;
    logic                       out_stall;
    logic [chi_pkg::HUE_W-1:0]  hue_out;
    logic                       zero_steps;
    int                         fail_count;
    int                         pending;
    int                         words_sent;
    int                         cycle_count;
    bit                         calm;

    circular_hue_interpolator_unit #(
        .HUE_STEPS(HUE_STEPS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_hue  (start_hue),
        .stop_hue   (stop_hue),
        .step_count (step_count),
        .step_index (step_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hue_out    (hue_out),
        .zero_steps (zero_steps)
    );

    hue_interp_checker #(
        .HUE_STEPS(HUE_STEPS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_hue  (start_hue),
        .stop_hue   (stop_hue),
        .step_count (step_count),
        .step_index (step_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hue_out    (hue_out),
        .zero_steps (zero_steps),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // Random output stalls, switched off during the calm stretch.
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    // Watchdog: ends the run if it hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Offers one word, after random idle cycles, and holds it until taken.
    // Called at a falling edge and returns at a falling edge.
    task automatic send_word(
        input int unsigned from_hue,
        input int unsigned to_hue,
        input int unsigned total,
        input int unsigned current
    );
        while (!calm && ($urandom_range(0, 99) < 13))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        start_hue  <= from_hue[chi_pkg::HUE_W-1:0];
        stop_hue   <= to_hue[chi_pkg::HUE_W-1:0];
        step_count <= total[chi_pkg::CNT_W-1:0];
        step_index <= current[chi_pkg::CNT_W-1:0];
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        calm = (words_sent >= CALM_FIRST) && (words_sent < CALM_LAST);
        @(negedge clk);
    endtask

    // Mostly hues on the circle, now and then codes at or above its size.
    function automatic int unsigned pick_hue();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(HUE_STEPS, (1 << chi_pkg::HUE_W) - 1);
        end
        return $urandom_range(0, HUE_STEPS - 1);
    endfunction

    function automatic int unsigned pick_count();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            return 0;
        end
        if (pick < 50)
        begin
            return $urandom_range(1, 64);
        end
        if (pick < 80)
        begin
            return $urandom_range(1, 4095);
        end
        return $urandom_range(0, (1 << chi_pkg::CNT_W) - 1);
    endfunction

    function automatic int unsigned pick_index(input int unsigned total);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10 && total < (1 << chi_pkg::CNT_W) - 1)
        begin
            return $urandom_range(total + 1, (1 << chi_pkg::CNT_W) - 1);
        end
        if (pick < 15)
        begin
            return 0;
        end
        if (pick < 20)
        begin
            return total;
        end
        return $urandom_range(0, total);
    endfunction

    // Reset, directed corners, then random fades and loose words.
    initial
    begin
        int unsigned from_hue;
        int unsigned to_hue;
        int unsigned total;
        int unsigned last_step;
        int unsigned mode;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        start_hue  = '0;
        stop_hue   = '0;
        step_count = '0;
        step_index = '0;
        words_sent = 0;
        calm       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero step count, including a start hue that needs reduction.
        send_word(0, 100, 0, 0);
        send_word(HUE_STEPS - 1, 5, 0, 65535);
        send_word(2047, 0, 0, 7);
        // Neighbors across the wrap point, both directions.
        send_word(0, HUE_STEPS - 1, 1, 1);
        send_word(HUE_STEPS - 1, 0, 65535, 1);
        send_word(HUE_STEPS - 1, 0, 65535, 65535);
        // Exactly half the circle apart takes the direct way.
        send_word(0, HALF_CIRCLE, 2, 1);
        send_word(HALF_CIRCLE, 0, 2, 1);
        send_word(100, 100 + HALF_CIRCLE, 65535, 32767);
        // Just over half the circle wraps.
        send_word(0, HALF_CIRCLE + 1, 2, 1);
        send_word(HALF_CIRCLE + 1, 0, 3, 2);
        // Step beyond the count is clamped to the stop hue.
        send_word(10, 500, 10, 65535);
        send_word(1200, 300, 1, 2);
        // Step zero and a single-step fade.
        send_word(300, 900, 1, 0);
        send_word(300, 900, 65535, 0);
        // Hues at or above the circle size are reduced first.
        send_word(2047, 1536, 4, 2);
        send_word(1536, 2047, 65535, 65534);
        send_word(2047, 2047, 65535, 65535);
        send_word(HUE_STEPS - 1, 1, 65535, 32768);

        while (words_sent < WORD_TARGET)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 60)
            begin
                // A whole fade, walked step by step, sometimes overshooting.
                from_hue = pick_hue();
                if ($urandom_range(0, 9) == 0)
                begin
                    to_hue = (from_hue % HUE_STEPS + HALF_CIRCLE) % HUE_STEPS;
                end
                else
                begin
                    to_hue = pick_hue();
                end
                total     = $urandom_range(1, 24);
                last_step = total + (($urandom_range(0, 3) == 0) ? 2 : 0);
                for (int unsigned k = 0; k <= last_step; k++)
                begin
                    send_word(from_hue, to_hue, total, k);
                end
            end
            else if (mode < 90)
            begin
                total = pick_count();
                send_word(pick_hue(), pick_hue(), total, pick_index(total));
            end
            else
            begin
                // Raw noise over the full width of every field.
                send_word($urandom_range(0, (1 << chi_pkg::HUE_W) - 1),
                          $urandom_range(0, (1 << chi_pkg::HUE_W) - 1),
                          $urandom_range(0, (1 << chi_pkg::CNT_W) - 1),
                          $urandom_range(0, (1 << chi_pkg::CNT_W) - 1));
            end
        end
        in_valid <= 1'b0;

        // Drain the pipeline, then give the verdict.
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
